>>> sv/mmh_pkg.sv
// ============================================================================
// mmh_pkg
// Shared types and codes for the min-max heap block.
// ============================================================================
`default_nettype none

package mmh_pkg;

    // Command codes.
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_DEL_MIN = 2'd1;
    localparam logic [1:0] CMD_DEL_MAX = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Command word.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } req_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] removed_value;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic [10:0]        count;
        logic [1:0]         status;
    } rsp_t;

endpackage

`default_nettype wire

>>> sv/mmh_ram.sv
// ============================================================================
// mmh_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
`default_nettype none

module mmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/min_max_heap_top.sv
// ============================================================================
// min_max_heap_top
// Double-ended priority queue kept as a min-max heap in one RAM.
// ============================================================================
//
//  channel   direction  handshake        payload
//  command   in         start / busy     req  (mmh_pkg::req_t)
//  result    out        done (1 cycle)   rsp  (mmh_pkg::rsp_t)
//
// One command word is handled at a time; busy stays high until it is done,
// and done comes in the same cycle that busy falls.
// Query and refused commands go straight to the readout of nodes one to
// three. An insert climbs by grandparent levels after the parent check; a
// delete searches level by level, paced by the single RAM read port that
// fetches the six children and grandchildren one after another.
// Reset empties the heap at once; the RAM contents need no clearing.
// The result word is valid on done, held until the next result, and cannot be stalled.
`default_nettype none

module min_max_heap_top #(
    parameter int DEPTH = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire mmh_pkg::req_t req,
    output logic               done,
    output mmh_pkg::rsp_t      rsp
);

    import mmh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam int CW = NW + 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BP   = 4'd1;
    localparam logic [3:0] S_BPW  = 4'd2;
    localparam logic [3:0] S_BG   = 4'd3;
    localparam logic [3:0] S_BGW  = 4'd4;
    localparam logic [3:0] S_DL   = 4'd5;
    localparam logic [3:0] S_TCHK = 4'd6;
    localparam logic [3:0] S_TRD  = 4'd7;
    localparam logic [3:0] S_TDEC = 4'd8;
    localparam logic [3:0] S_TWP  = 4'd9;
    localparam logic [3:0] S_TWC  = 4'd10;
    localparam logic [3:0] S_F1   = 4'd11;
    localparam logic [3:0] S_F2   = 4'd12;
    localparam logic [3:0] S_F3   = 4'd13;
    localparam logic [3:0] S_F4   = 4'd14;

    // True when the node sits on a min level (even depth).
    function automatic logic on_min(input logic [CW-1:0] n);
        logic lvl_odd;
        lvl_odd = 1'b0;
        for (int b = 0; b < CW; b++)
        begin
            if (n[b])
            begin
                lvl_odd = b[0];
            end
        end
        return ~lvl_odd;
    endfunction

    // True when a should sit above b in the given sense.
    function automatic logic better(input logic signed [31:0] a,
                                    input logic signed [31:0] b,
                                    input logic is_min);
        return is_min ? (a < b) : (a > b);
    endfunction

    // Child and grandchild candidates of node i, in search order.
    function automatic logic [CW-1:0] cand(input logic [CW-1:0] i, input logic [2:0] k);
        logic [CW-1:0] r;
        if (k == 3'd0)
        begin
            r = {i[CW-2:0], 1'b0};
        end
        else if (k == 3'd1)
        begin
            r = {i[CW-2:0], 1'b1};
        end
        else
        begin
            r = {i[CW-3:0], 2'b00} + CW'(k - 3'd2);
        end
        return r;
    endfunction

    logic [3:0]         state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic signed [31:0] x_reg, x_next;
    logic [CW-1:0]      i_reg, i_next;
    logic               kind_reg, kind_next;
    logic signed [31:0] removed_reg, removed_next;
    logic [1:0]         status_reg, status_next;
    logic [NW-1:0]      count_reg, count_next;
    logic signed [31:0] bestv_reg, bestv_next;
    logic [CW-1:0]      bestn_reg, bestn_next;
    logic signed [31:0] c0_reg, c0_next;
    logic signed [31:0] c1_reg, c1_next;
    logic [2:0]         k_reg, k_next;
    logic [CW-1:0]      wpn_reg, wpn_next;
    logic signed [31:0] wpv_reg, wpv_next;
    logic signed [31:0] r1_reg, r1_next;
    logic signed [31:0] r2_reg, r2_next;
    logic signed [31:0] r3_reg, r3_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic               we;
    logic [CW-1:0]      wnode, rnode, wnode_m1, rnode_m1;
    logic signed [31:0] wdata, rdata;
    logic [31:0]        rdata_raw;
    logic [CW-1:0]      n_ext, pnode, prev_node, mnode;
    logic               pmin;
    logic signed [31:0] kp;

    assign n_ext    = CW'(count_reg);
    assign wnode_m1 = wnode - CW'(1);
    assign rnode_m1 = rnode - CW'(1);
    assign rdata    = $signed(rdata_raw);

    mmh_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(wnode_m1[AW-1:0]),
        .wdata(wdata),
        .raddr(rnode_m1[AW-1:0]),
        .rdata(rdata_raw)
    );

    // Sequencer: bubble-up, trickle-down and result readout.
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        i_next       = i_reg;
        kind_next    = kind_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        bestv_next   = bestv_reg;
        bestn_next   = bestn_reg;
        c0_next      = c0_reg;
        c1_next      = c1_reg;
        k_next       = k_reg;
        wpn_next     = wpn_reg;
        wpv_next     = wpv_reg;
        r1_next      = r1_reg;
        r2_next      = r2_reg;
        r3_next      = r3_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        we           = 1'b0;
        wnode        = i_reg;
        wdata        = x_reg;
        rnode        = CW'(1);
        pnode        = i_reg >> 1;
        pmin         = on_min(i_reg >> 1);
        prev_node    = cand(i_reg, k_reg - 3'd1);
        mnode        = bestn_reg >> 1;
        kp           = (mnode == {i_reg[CW-2:0], 1'b0}) ? c0_reg : c1_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = req.cmd;
                    removed_next = '0;
                    status_next  = STAT_OK;
                    unique case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (n_ext >= CW'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_F1;
                            end
                            else
                            begin
                                count_next = count_reg + NW'(1);
                                x_next     = req.value;
                                i_next     = n_ext + CW'(1);
                                state_next = (count_reg == '0) ? S_BG : S_BP;
                            end
                        end
                        CMD_DEL_MIN, CMD_DEL_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_F1;
                            end
                            else
                            begin
                                // Pick the hole: root for min or a lone key, else larger child for max.
                                if (req.cmd == CMD_DEL_MIN || count_reg == NW'(1))
                                begin
                                    i_next       = CW'(1);
                                    removed_next = r1_reg;
                                end
                                else if (count_reg >= NW'(3) && r3_reg > r2_reg)
                                begin
                                    i_next       = CW'(3);
                                    removed_next = r3_reg;
                                end
                                else
                                begin
                                    i_next       = CW'(2);
                                    removed_next = r2_reg;
                                end
                                rnode      = n_ext;
                                count_next = count_reg - NW'(1);
                                state_next = S_DL;
                            end
                        end
                        CMD_QUERY:
                        begin
                            state_next = S_F1;
                        end
                    endcase
                end
            end

            S_BP:
            begin
                rnode      = pnode;
                state_next = S_BPW;
            end

            S_BPW:
            begin
                // Compare against the parent on the other kind of level.
                if (better(x_reg, rdata, pmin))
                begin
                    we        = 1'b1;
                    wnode     = i_reg;
                    wdata     = rdata;
                    i_next    = pnode;
                    kind_next = pmin;
                end
                else
                begin
                    kind_next = ~pmin;
                end
                state_next = S_BG;
            end

            S_BG:
            begin
                if (i_reg >= CW'(4))
                begin
                    rnode      = i_reg >> 2;
                    state_next = S_BGW;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_F1;
                end
            end

            S_BGW:
            begin
                // Climb by grandparents while the key beats them.
                we = 1'b1;
                if (better(x_reg, rdata, kind_reg))
                begin
                    wdata      = rdata;
                    i_next     = i_reg >> 2;
                    state_next = S_BG;
                end
                else
                begin
                    state_next = S_F1;
                end
            end

            S_DL:
            begin
                x_next = rdata;
                if (i_reg <= n_ext)
                begin
                    kind_next  = on_min(i_reg);
                    state_next = S_TCHK;
                end
                else
                begin
                    state_next = S_F1;
                end
            end

            S_TCHK:
            begin
                if ({i_reg[CW-2:0], 1'b0} > n_ext || i_reg[CW-1])
                begin
                    we         = 1'b1;
                    state_next = S_F1;
                end
                else
                begin
                    rnode      = cand(i_reg, 3'd0);
                    k_next     = 3'd1;
                    state_next = S_TRD;
                end
            end

            S_TRD:
            begin
                // One candidate arrives per cycle; keep the best, lowest node on ties.
                if (k_reg == 3'd1)
                begin
                    bestv_next = rdata;
                    bestn_next = prev_node;
                    c0_next    = rdata;
                end
                else
                begin
                    if (k_reg == 3'd2)
                    begin
                        c1_next = rdata;
                    end
                    if (prev_node <= n_ext && better(rdata, bestv_reg, kind_reg))
                    begin
                        bestv_next = rdata;
                        bestn_next = prev_node;
                    end
                end
                if (k_reg == 3'd6)
                begin
                    state_next = S_TDEC;
                end
                else
                begin
                    rnode  = cand(i_reg, k_reg);
                    k_next = k_reg + 3'd1;
                end
            end

            S_TDEC:
            begin
                we = 1'b1;
                if (bestn_reg >= {i_reg[CW-3:0], 2'b00})
                begin
                    if (!better(bestv_reg, x_reg, kind_reg))
                    begin
                        state_next = S_F1;
                    end
                    else
                    begin
                        wdata  = bestv_reg;
                        i_next = bestn_reg;
                        if (better(kp, x_reg, kind_reg))
                        begin
                            wpn_next   = mnode;
                            wpv_next   = x_reg;
                            x_next     = kp;
                            state_next = S_TWP;
                        end
                        else
                        begin
                            state_next = S_TCHK;
                        end
                    end
                end
                else if (better(bestv_reg, x_reg, kind_reg))
                begin
                    wdata      = bestv_reg;
                    state_next = S_TWC;
                end
                else
                begin
                    state_next = S_F1;
                end
            end

            S_TWP:
            begin
                we         = 1'b1;
                wnode      = wpn_reg;
                wdata      = wpv_reg;
                state_next = S_TCHK;
            end

            S_TWC:
            begin
                we         = 1'b1;
                wnode      = bestn_reg;
                state_next = S_F1;
            end

            S_F1:
            begin
                rnode      = CW'(1);
                state_next = S_F2;
            end

            S_F2:
            begin
                rnode      = CW'(2);
                r1_next    = rdata;
                state_next = S_F3;
            end

            S_F3:
            begin
                rnode      = CW'(3);
                r2_next    = rdata;
                state_next = S_F4;
            end

            S_F4:
            begin
                // Build the result word from nodes one to three.
                r3_next               = rdata;
                rsp_next.removed_value = removed_reg;
                rsp_next.count         = 11'(count_reg);
                rsp_next.status        = status_reg;
                if (count_reg == '0)
                begin
                    rsp_next.min_value = '0;
                    rsp_next.max_value = '0;
                end
                else
                begin
                    rsp_next.min_value = r1_reg;
                    if (count_reg == NW'(1))
                    begin
                        rsp_next.max_value = r1_reg;
                    end
                    else if (count_reg >= NW'(3) && rdata > r2_reg)
                    begin
                        rsp_next.max_value = rdata;
                    end
                    else
                    begin
                        rsp_next.max_value = r2_reg;
                    end
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        i_reg       <= i_next;
        kind_reg    <= kind_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        bestv_reg   <= bestv_next;
        bestn_reg   <= bestn_next;
        c0_reg      <= c0_next;
        c1_reg      <= c1_next;
        k_reg       <= k_next;
        wpn_reg     <= wpn_next;
        wpv_reg     <= wpv_next;
        r1_reg      <= r1_next;
        r2_reg      <= r2_next;
        r3_reg      <= r3_next;
        rsp_reg     <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // The result strobe only comes once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // The heap never holds more keys than the store has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("entry count over depth");

    // An accepted command word always makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command not taken");

    // A refused insert leaves the count at the full mark.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_FULL) |-> (count_reg == NW'(DEPTH)))
        else $error("full status with room left");

endmodule

`default_nettype wire

>>> sim/mmh_checker.sv
// ============================================================================
// mmh_checker
// Watches the command and result channels of the min-max heap, keeps its own
// heap image to work out each result word, and counts mismatches.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mmh_checker #(
    parameter int DEPTH = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire mmh_pkg::req_t req,
    input  wire logic          done,
    input  wire mmh_pkg::rsp_t rsp,
    output int                 fail_count,
    output int                 pending
);
    import mmh_pkg::*;

    logic signed [31:0] heap_keys [1:DEPTH];
    int unsigned        key_total;
    rsp_t               expected_words [$];

    // Level parity of a node: the root is on a min level.
    function automatic bit is_min_level(int unsigned node);
        int unsigned lvl;
        lvl = 0;
        while (node > 1)
        begin
            node = node >> 1;
            lvl++;
        end
        return (lvl % 2) == 0;
    endfunction

    function automatic bit beats(logic signed [31:0] a, logic signed [31:0] b, bit want_min);
        return want_min ? (a < b) : (a > b);
    endfunction

    function automatic void swap_keys(int unsigned a, int unsigned b);
        logic signed [31:0] t;
        t = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic void climb_grandparents(int unsigned i, bit want_min);
        while (i >= 4 && beats(heap_keys[i], heap_keys[i >> 2], want_min))
        begin
            swap_keys(i, i >> 2);
            i = i >> 2;
        end
    endfunction

    // Standard min-max heap bubble-up after an insert at node i.
    function automatic void bubble_up(int unsigned i);
        int unsigned p;
        bit          pmin;
        if (i <= 1)
            return;
        p = i >> 1;
        pmin = is_min_level(p);
        if (beats(heap_keys[i], heap_keys[p], pmin))
        begin
            swap_keys(i, p);
            climb_grandparents(p, pmin);
        end
        else
            climb_grandparents(i, !pmin);
    endfunction

    // Trickle-down over children and grandchildren; ties keep the lowest node.
    function automatic void trickle_down(int unsigned i);
        bit          want_min;
        int unsigned m;
        int unsigned c;
        want_min = is_min_level(i);
        forever
        begin
            if (2 * i > key_total)
                return;
            m = 2 * i;
            for (int k = 1; k < 6; k++)
            begin
                c = (k == 1) ? 2 * i + 1 : 4 * i + (k - 2);
                if (c <= key_total && beats(heap_keys[c], heap_keys[m], want_min))
                    m = c;
            end
            if (m >= 4 * i)
            begin
                if (!beats(heap_keys[m], heap_keys[i], want_min))
                    return;
                swap_keys(m, i);
                if (beats(heap_keys[m >> 1], heap_keys[m], want_min))
                    swap_keys(m, m >> 1);
                i = m;
            end
            else
            begin
                if (beats(heap_keys[m], heap_keys[i], want_min))
                    swap_keys(m, i);
                return;
            end
        end
    endfunction

    function automatic int unsigned largest_node();
        if (key_total == 1)
            return 1;
        if (key_total >= 3 && heap_keys[3] > heap_keys[2])
            return 3;
        return 2;
    endfunction

    function automatic logic signed [31:0] take_node(int unsigned m);
        logic signed [31:0] r;
        r = heap_keys[m];
        heap_keys[m] = heap_keys[key_total];
        key_total--;
        if (m <= key_total)
            trickle_down(m);
        return r;
    endfunction

    // Applies one command word and returns the result word it must produce.
    function automatic rsp_t heap_result(req_t w);
        rsp_t r;
        r = '0;
        r.status = STAT_OK;
        case (w.cmd)
            CMD_INSERT:
                if (key_total >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    key_total++;
                    heap_keys[key_total] = w.value;
                    bubble_up(key_total);
                end
            CMD_DEL_MIN, CMD_DEL_MAX:
                if (key_total == 0)
                    r.status = STAT_EMPTY;
                else
                    r.removed_value = take_node(w.cmd == CMD_DEL_MIN ? 1 : largest_node());
            default: ;
        endcase
        if (key_total != 0)
        begin
            r.min_value = heap_keys[1];
            r.max_value = heap_keys[largest_node()];
        end
        r.count = key_total[10:0];
        return r;
    endfunction

    assign pending = expected_words.size();

    // Predict on accepted commands, compare on each done strobe.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            key_total = 0;
            fail_count <= 0;
            expected_words.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %p", rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_words.push_back(heap_result(req));
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ============================================================================
// tb_top
// Drives directed and random command words into the min-max heap, including
// fill-to-full and drain-to-empty runs, and reports the checker's verdict.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import mmh_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int IDLE_LIM  = 20000;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;
    int    fail_count;
    int    pending;
    int    idle_cycles = 0;

    min_max_heap_top #(.DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .rsp(rsp)
    );

    mmh_checker #(.DEPTH(DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on cycles with no word accepted on either channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sends one word after a random gap and holds start until it is taken.
    // Start stays high after the word is taken, so a word with no gap follows
    // directly; a gap drops start first.
    task automatic send_word(logic [1:0] c, logic signed [31:0] v, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{cmd: c, value: v};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drops start and waits until every expected result word has come.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic signed [31:0] random_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15) - 8;
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int  r;
        bit  burst;
        bit  draining;
        logic [1:0] c;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty deletes, extremes, ties, then drain.
        send_word(CMD_DEL_MIN, 0, 0);
        send_word(CMD_DEL_MAX, 0, 0);
        send_word(CMD_QUERY, 32'sh7FFFFFFF, 0);
        send_word(CMD_INSERT, 32'sh7FFFFFFF, 0);
        send_word(CMD_INSERT, 32'sh80000000, 0);
        send_word(CMD_INSERT, 0, 0);
        send_word(CMD_INSERT, -1, 0);
        send_word(CMD_INSERT, 5, 0);
        send_word(CMD_INSERT, 5, 0);
        send_word(CMD_INSERT, 5, 1);
        send_word(CMD_QUERY, 0, 1);
        send_word(CMD_DEL_MAX, 0, 0);
        send_word(CMD_DEL_MIN, 0, 0);
        for (int i = 0; i < 6; i++)
            send_word(i % 2 ? CMD_DEL_MIN : CMD_DEL_MAX, 0, 0);

        // Wait for every result before the random part.
        wait_drained();

        // Random mix around a small heap, ending with a drain phase of mostly deletes.
        draining = 1'b0;
        for (int i = 0; i < 40; i++)
        begin
            r = $urandom_range(0, 99);
            if (i == 25)
                draining = 1'b1;
            if (draining)
                c = (r < 90) ? ((r % 2 == 0) ? CMD_DEL_MIN : CMD_DEL_MAX) : CMD_QUERY;
            else
                c = (r < 45) ? CMD_INSERT : (r < 70) ? CMD_DEL_MIN
                    : (r < 95) ? CMD_DEL_MAX : CMD_QUERY;
            send_word(c, random_key(), (i % 10) < 3);
        end

        // Fill to full with burst stretches, then refused inserts, a delete of each kind and a query.
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i % 64 == 0)
                burst = ($urandom_range(0, 1) == 1);
            send_word(CMD_INSERT, random_key(), burst);
        end
        send_word(CMD_INSERT, 32'sh80000000, 0);
        send_word(CMD_INSERT, 32'sh7FFFFFFF, 0);
        send_word(CMD_DEL_MAX, 0, 0);
        send_word(CMD_DEL_MIN, 0, 0);
        send_word(CMD_QUERY, 0, 0);

        // Drain partly, mixing both delete kinds.
        for (int i = 0; i < 20; i++)
            send_word($urandom_range(0, 1) ? CMD_DEL_MIN : CMD_DEL_MAX, 0, i < 8);

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
sv/mmh_pkg.sv
sv/mmh_ram.sv
sv/min_max_heap_top.sv
sim/mmh_checker.sv
sim/tb_top.sv
